FILE: hw/rtl/mst_pkg.sv
`timescale 1ns / 1ps

package mst_pkg;

    // Table size default
    localparam int MAX_TIMERS_DEF = 32;

    // Field widths
    localparam int OP_W       = 2;
    localparam int ID_W       = 5;
    localparam int START_W    = 24;
    localparam int INTV_W     = 24;
    localparam int ELAPSED_W  = 16;
    localparam int REM_W      = 32;
    localparam int KIND_W     = 3;
    localparam int S_DATA_W   = 72;
    localparam int M_DATA_W   = 8;

    // Width used for id and index comparisons, wide enough for a table of 64
    localparam int IDX_CMP_W  = 7;

    // Result cap per input item; the pending result is the last of them
    localparam int MAX_RESULTS = 32;
    localparam int EMIT_LIMIT  = MAX_RESULTS - 1;
    localparam int EMIT_W      = $clog2(MAX_RESULTS);

    // Operation codes
    localparam logic [OP_W-1:0] OP_TICK  = 2'd0;
    localparam logic [OP_W-1:0] OP_START = 2'd1;
    localparam logic [OP_W-1:0] OP_STOP  = 2'd2;

    // Result kinds
    localparam logic [KIND_W-1:0] K_STARTED   = 3'd0;
    localparam logic [KIND_W-1:0] K_STOPPED   = 3'd1;
    localparam logic [KIND_W-1:0] K_START_REJ = 3'd2;
    localparam logic [KIND_W-1:0] K_STOP_REJ  = 3'd3;
    localparam logic [KIND_W-1:0] K_EXPIRED   = 3'd4;
    localparam logic [KIND_W-1:0] K_IDLE_TICK = 3'd5;

    // One slot word in the slot memory
    typedef struct packed {
        logic              one_shot;
        logic [INTV_W-1:0] interval;
        logic [REM_W-1:0]  remaining;
    } slot_word_t;

    localparam int SLOT_W = $bits(slot_word_t);

    // Update unit result
    typedef struct packed {
        logic             expired;
        logic [REM_W-1:0] remaining;
    } alu_res_t;

endpackage

FILE: hw/rtl/multi_slot_software_timer.sv
`timescale 1ns / 1ps

// Timer table of MAX_TIMERS one-shot or periodic slots. A start or stop transfer
// passes through a command state and returns one result. A tick transfer walks
// every slot in id order, one slot per cycle while the result channel does not
// hold off a result, through a single subtract/reload unit fed by the registered
// read port of the slot memory. An expiry is kept back one step so that the
// final result of a tick carries tlast; a tick with no expiry returns one
// idle-tick result. Input tuser is the operation; input tdata packs, from bit 0:
// timer_id, start_remaining, interval_ms, one_shot, elapsed_ms. Output tdata
// packs kind, then expired_id, and tlast marks the last result of an input
// transfer. Operation code 3 is dropped without a result. The slot memory needs
// no clearing after reset; of the slot state, only the active bits are reset.
module multi_slot_software_timer
    import mst_pkg::*;
#(
    parameter int MAX_TIMERS = MAX_TIMERS_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    // timer_id, start_remaining, interval_ms, one_shot, elapsed_ms, zero fill
    input  logic [S_DATA_W-1:0] s_axis_tdata,
    // op
    input  logic [OP_W-1:0]     s_axis_tuser,
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    // kind, expired_id
    output logic [M_DATA_W-1:0] m_axis_tdata,
    output logic                m_axis_tlast
);

    localparam int IDX_W = $clog2(MAX_TIMERS);
    localparam logic [IDX_CMP_W-1:0] MAX_CMP  = IDX_CMP_W'(MAX_TIMERS);
    localparam logic [IDX_W-1:0]     LAST_IDX = IDX_W'(MAX_TIMERS - 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CMD,
        ST_TRD,
        ST_TWALK,
        ST_TDONE
    } state_t;

    state_t                state_reg;
    logic [OP_W-1:0]       op_reg;
    logic [ID_W-1:0]       id_reg;
    logic [START_W-1:0]    start_reg;
    logic [INTV_W-1:0]     intv_reg;
    logic                  os_reg;
    logic [ELAPSED_W-1:0]  elapsed_reg;
    logic [MAX_TIMERS-1:0] active_reg;
    logic [IDX_W-1:0]      idx_reg;
    logic                  pend_valid_reg;
    logic [ID_W-1:0]       pend_id_reg;
    logic [EMIT_W-1:0]     emit_cnt_reg;
    logic                  m_valid_reg;
    logic [KIND_W-1:0]     m_kind_reg;
    logic [ID_W-1:0]       m_id_reg;
    logic                  m_last_reg;

    logic                  in_xfer;
    logic                  out_free;
    logic [IDX_CMP_W-1:0]  id_ext;
    logic                  id_ok;
    logic [IDX_W-1:0]      cmd_idx;
    logic [IDX_CMP_W-1:0]  idx_ext;
    logic                  slot_act;
    logic                  slot_exp;
    logic                  cap_hit;
    logic                  stall;
    logic                  res_load;
    logic                  mem_we;
    logic [IDX_W-1:0]      mem_waddr;
    slot_word_t            mem_wdata;
    logic                  mem_re;
    logic [IDX_W-1:0]      mem_raddr;
    slot_word_t            mem_rdata;
    alu_res_t              alu_res;

    // Storage for slot data
    mst_slot_ram #(
        .DEPTH  (MAX_TIMERS),
        .ADDR_W (IDX_W)
    ) u_ram (
        .aclk    (aclk),
        .we      (mem_we),
        .wr_addr (mem_waddr),
        .wr_data (mem_wdata),
        .rd_en   (mem_re),
        .rd_addr (mem_raddr),
        .rd_data (mem_rdata)
    );

    // Shared update unit for the tick walk
    mst_slot_alu u_alu (
        .remaining (mem_rdata.remaining),
        .elapsed   (elapsed_reg),
        .interval  (mem_rdata.interval),
        .res       (alu_res)
    );

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign in_xfer       = s_axis_tvalid & s_axis_tready;
    assign out_free      = ~m_valid_reg | m_axis_tready;

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {m_id_reg, m_kind_reg};
    assign m_axis_tlast  = m_last_reg;

    // Decode addressed slot and walk position
    assign id_ext   = IDX_CMP_W'(id_reg);
    assign id_ok    = id_ext < MAX_CMP;
    assign cmd_idx  = id_ext[IDX_W-1:0];
    assign idx_ext  = IDX_CMP_W'(idx_reg);
    assign slot_act = active_reg[idx_reg];
    assign slot_exp = slot_act & alu_res.expired;
    assign cap_hit  = (emit_cnt_reg == EMIT_W'(EMIT_LIMIT));
    assign stall    = slot_exp & pend_valid_reg & ~cap_hit & ~out_free;

    // Load a new result into the output register
    assign res_load = ((state_reg == ST_CMD) & out_free)
                    | ((state_reg == ST_TWALK) & ~stall & slot_exp & pend_valid_reg & ~cap_hit)
                    | ((state_reg == ST_TDONE) & out_free);

    // Drive the memory ports
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = idx_reg;
        mem_wdata = '{one_shot: mem_rdata.one_shot, interval: mem_rdata.interval,
                      remaining: alu_res.remaining};
        mem_re    = 1'b0;
        mem_raddr = idx_reg + 1'b1;
        case (state_reg)
            ST_CMD: begin
                mem_waddr = cmd_idx;
                mem_wdata = '{one_shot: os_reg, interval: intv_reg,
                              remaining: REM_W'(start_reg)};
                mem_we    = (op_reg == OP_START) & id_ok & ~active_reg[cmd_idx] & out_free;
            end
            ST_TRD: begin
                mem_re    = 1'b1;
                mem_raddr = '0;
            end
            ST_TWALK: begin
                mem_we = ~stall & slot_act;
                mem_re = ~stall & (idx_reg != LAST_IDX);
            end
            default: begin
            end
        endcase
    end

    // Sequencer, slot flags and result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            active_reg     <= '0;
            idx_reg        <= '0;
            pend_valid_reg <= 1'b0;
            emit_cnt_reg   <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            // Raise valid on a new result, drop it once the held one is taken
            if (res_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_axis_tready) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (in_xfer) begin
                        op_reg      <= s_axis_tuser;
                        id_reg      <= s_axis_tdata[4:0];
                        start_reg   <= s_axis_tdata[28:5];
                        intv_reg    <= s_axis_tdata[52:29];
                        os_reg      <= s_axis_tdata[53];
                        elapsed_reg <= s_axis_tdata[69:54];
                        case (s_axis_tuser)
                            OP_TICK:  state_reg <= ST_TRD;
                            OP_START: state_reg <= ST_CMD;
                            OP_STOP:  state_reg <= ST_CMD;
                            default:  state_reg <= ST_IDLE;
                        endcase
                    end
                end
                ST_CMD: begin
                    if (out_free) begin
                        m_id_reg    <= id_reg;
                        m_last_reg  <= 1'b1;
                        if (op_reg == OP_START) begin
                            if (id_ok && !active_reg[cmd_idx]) begin
                                active_reg[cmd_idx] <= 1'b1;
                                m_kind_reg          <= K_STARTED;
                            end else begin
                                m_kind_reg <= K_START_REJ;
                            end
                        end else begin
                            if (id_ok && active_reg[cmd_idx]) begin
                                active_reg[cmd_idx] <= 1'b0;
                                m_kind_reg          <= K_STOPPED;
                            end else begin
                                m_kind_reg <= K_STOP_REJ;
                            end
                        end
                        state_reg <= ST_IDLE;
                    end
                end
                ST_TRD: begin
                    idx_reg   <= '0;
                    state_reg <= ST_TWALK;
                end
                ST_TWALK: begin
                    if (!stall) begin
                        if (slot_exp) begin
                            if (mem_rdata.one_shot) begin
                                active_reg[idx_reg] <= 1'b0;
                            end
                            // Hold the first expiry; below the cap, release the held one and keep the newest back
                            if (!pend_valid_reg) begin
                                pend_valid_reg <= 1'b1;
                                pend_id_reg    <= idx_ext[ID_W-1:0];
                            end else if (!cap_hit) begin
                                m_kind_reg   <= K_EXPIRED;
                                m_id_reg     <= pend_id_reg;
                                m_last_reg   <= 1'b0;
                                emit_cnt_reg <= emit_cnt_reg + 1'b1;
                                pend_id_reg  <= idx_ext[ID_W-1:0];
                            end
                        end
                        if (idx_reg == LAST_IDX) begin
                            state_reg <= ST_TDONE;
                        end else begin
                            idx_reg <= idx_reg + 1'b1;
                        end
                    end
                end
                ST_TDONE: begin
                    if (out_free) begin
                        m_last_reg     <= 1'b1;
                        m_kind_reg     <= pend_valid_reg ? K_EXPIRED : K_IDLE_TICK;
                        m_id_reg       <= pend_valid_reg ? pend_id_reg : '0;
                        pend_valid_reg <= 1'b0;
                        emit_cnt_reg   <= '0;
                        state_reg      <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // No expiry is left over once the block takes a new transfer
    a_idle_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        s_axis_tready |-> (!pend_valid_reg && emit_cnt_reg == '0))
        else $error("expiry state not cleared at idle");

    // Released expiries always leave one held back for the final result
    a_emit_pend: assert property (@(posedge aclk) disable iff (!aresetn)
        (emit_cnt_reg != '0) |-> pend_valid_reg)
        else $error("expiry released without a held one");

    // Walk index stays inside the table
    a_idx_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_TWALK) |-> (idx_ext < MAX_CMP))
        else $error("walk index beyond table");

    // A result is never overwritten while the channel holds it off
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_axis_tready && state_reg == ST_TWALK) |=>
            $stable(m_kind_reg) && $stable(m_id_reg) && $stable(m_last_reg))
        else $error("result overwritten while stalled");

endmodule

FILE: hw/rtl/mst_slot_ram.sv
`timescale 1ns / 1ps

module mst_slot_ram
    import mst_pkg::*;
#(
    parameter int DEPTH  = MAX_TIMERS_DEF,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [ADDR_W-1:0] wr_addr,
    input  slot_word_t        wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output slot_word_t        rd_data
);

    slot_word_t mem [DEPTH];
    slot_word_t rd_data_reg;

    // Write port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: hw/rtl/mst_slot_alu.sv
`timescale 1ns / 1ps

module mst_slot_alu
    import mst_pkg::*;
(
    input  logic [REM_W-1:0]     remaining,
    input  logic [ELAPSED_W-1:0] elapsed,
    input  logic [INTV_W-1:0]    interval,
    output alu_res_t             res
);

    logic [REM_W:0]   diff;
    logic [REM_W-1:0] sat;
    logic             underflow;

    // Subtract elapsed time with one guard bit
    assign diff = {remaining[REM_W-1], remaining} - {{(REM_W+1-ELAPSED_W){1'b0}}, elapsed};

    // Clamp at the most negative value
    assign underflow = diff[REM_W] & ~diff[REM_W-1];
    assign sat       = underflow ? {1'b1, {(REM_W-1){1'b0}}} : diff[REM_W-1:0];

    // Reload with the interval on expiry
    assign res.expired   = sat[REM_W-1];
    assign res.remaining = sat[REM_W-1] ? sat + {{(REM_W-INTV_W){1'b0}}, interval} : sat;

endmodule
